>>> rtl/core/midi_track_event_serializer_core_assert.svh
// Assertion macros for the MIDI track event serializer core.
// Files that check their own logic include this header; it has no other dependencies.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef MIDI_TRACK_EVENT_SERIALIZER_CORE_ASSERT_SVH
`define MIDI_TRACK_EVENT_SERIALIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define MTES_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define MTES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MTES_ASSERT_IMPLY(label, ante, cons, msg)
`define MTES_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/core/mtes_pkg.sv
// Shared types, codes and constants for the MIDI track event serializer core.
// This package has no dependencies; every module of the core imports it.
`timescale 1ns / 1ps

package mtes_pkg;

	// Sizes.
	localparam int TRACK_COUNT_DEF = 16;
	localparam int TRK_W           = 4;
	localparam int DELAY_W         = 28;
	localparam int VOL_W           = 8;
	localparam int BPM_W           = 10;
	localparam int TEMPO_W         = 24;
	localparam int MAX_BYTES       = 7;

	// The saturation limit of a delta; it also fits in four varlen bytes.
	localparam logic [DELAY_W-1:0] DELAY_MAX = 28'hFFFFFFF;

	// Microseconds per minute, divided by the bpm for a tempo event.
	localparam logic [25:0] TEMPO_NUM = 26'd60000000;
	localparam int          DIV_STEPS = 26;

	// Status and meta bytes.
	localparam logic [7:0] STAT_NOTE_OFF = 8'h80;
	localparam logic [7:0] STAT_NOTE_ON  = 8'h90;
	localparam logic [7:0] STAT_CTRL     = 8'hB0;
	localparam logic [7:0] STAT_PROGRAM  = 8'hC0;
	localparam logic [7:0] CTRL_VOLUME   = 8'h07;
	localparam logic [7:0] META_START    = 8'hFF;
	localparam logic [7:0] META_TEMPO    = 8'h51;
	localparam logic [7:0] META_TEMPO_LN = 8'h03;
	localparam logic [7:0] META_END      = 8'h2F;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] VOL_MIN       = 8'h01;
	localparam logic [7:0] VOL_MAX       = 8'hFF;

	typedef enum logic [2:0] {
		ACT_NOTE_ON  = 3'd0,
		ACT_NOTE_OFF = 3'd1,
		ACT_PROGRAM  = 3'd2,
		ACT_VOLUME   = 3'd3,
		ACT_RATIO    = 3'd4,
		ACT_PAUSE    = 3'd5,
		ACT_TEMPO    = 3'd6,
		ACT_END      = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_EMIT
	} state_t;

	// One entry of the per-track state memory.
	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [VOL_W-1:0]   volume;
	} trk_entry_t;

	// Write port of the per-track state memory.
	typedef struct packed {
		logic             en;
		logic [TRK_W-1:0] addr;
		trk_entry_t       data;
	} mem_wr_t;

	// Status of the tempo divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// One encoded event handed to the byte serializer; byte 0 goes out first.
	typedef struct packed {
		logic                      load;
		logic [2:0]                count;
		logic [MAX_BYTES-1:0][7:0] bytes;
	} ser_load_t;

endpackage

>>> rtl/core/mtes_track_mem.sv
// Per-track state memory: pending delay and volume, one entry per track.
// Depends on mtes_pkg; synchronous read, one write port.
`timescale 1ns / 1ps

module mtes_track_mem import mtes_pkg::*; #(
	parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [TRK_W-1:0] rd_addr,
	output trk_entry_t       rd_data,
	input  mem_wr_t          wr
);

	localparam int AW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

	trk_entry_t             mem_q [TRACK_COUNT];
	logic [TRACK_COUNT-1:0] valid_q;
	trk_entry_t             rd_entry_s1;
	logic                   rd_vld_s1;

	// Storage array, written in place.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	// Registered read of the entry and its written flag.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_s1 <= mem_q[rd_addr[AW-1:0]];
			rd_vld_s1   <= valid_q[rd_addr[AW-1:0]];
		end
	end

	// An entry counts as zero until its first write after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr[AW-1:0]] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_s1 ? rd_entry_s1 : '0;

endmodule

>>> rtl/core/mtes_tempo_div.sv
// Iterative restoring divider for the tempo value: 60000000 divided by the bpm.
// Depends on mtes_pkg; one quotient bit per cycle, DIV_STEPS quotient bits per division.
`timescale 1ns / 1ps

module mtes_tempo_div import mtes_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BPM_W-1:0]   divisor,
	output div_stat_t          stat,
	output logic [TEMPO_W-1:0] quotient
);

	logic [BPM_W-1:0] rem_q;
	logic [BPM_W-1:0] dvs_q;
	logic [25:0]      num_q;
	logic [25:0]      quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BPM_W:0]   trial;
	logic [BPM_W:0]   diff;
	logic             fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial = {rem_q, num_q[25]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Datapath: remainder, dividend and quotient shift one bit per step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			num_q <= TEMPO_NUM;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
			num_q <= {num_q[24:0], 1'b0};
			quo_q <= {quo_q[24:0], fits};
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= 5'(DIV_STEPS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q[TEMPO_W-1:0];

endmodule

>>> rtl/core/mtes_byte_ser.sv
// Byte serializer: holds one encoded event and sends it one byte per transfer.
// Depends on mtes_pkg; the output side is a registered stream with tlast on the final byte.
`timescale 1ns / 1ps

module mtes_byte_ser import mtes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ser_load_t  ld,
	output logic       ready,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	logic [MAX_BYTES-1:0][7:0] shreg_q;
	logic [2:0]                cnt_q;
	logic                      xfer;

	assign xfer = m_axis_tvalid && m_axis_tready;

	// A new event may load once the last byte of the current one is leaving.
	assign ready = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && m_axis_tready);

	// Byte shift register: the byte on the port is always element zero.
	always_ff @(posedge clk) begin
		if (ld.load) begin
			shreg_q <= ld.bytes;
		end else if (xfer) begin
			shreg_q <= {BYTE_ZERO, shreg_q[MAX_BYTES-1:1]};
		end
	end

	// Count of bytes still to send.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ld.load) begin
			cnt_q <= ld.count;
		end else if (xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	assign m_axis_tvalid = cnt_q != 3'd0;
	assign m_axis_tdata  = shreg_q[0];
	assign m_axis_tlast  = cnt_q == 3'd1;

endmodule

>>> rtl/core/midi_track_event_serializer_core.sv
// Encodes one MIDI track event per input transfer into its Standard MIDI File bytes, sent
// one byte per output transfer with tlast on the final byte of the event. Per-track pending
// delay and volume live in a small synchronous memory that each event reads, updates and
// writes back before the next event is taken, so accesses to one entry never overlap.
// An event passes through the registered memory read and the registered arithmetic stage; a
// tempo event with a nonzero bpm then waits for the bit-serial divider. The encoded bytes
// load into the output serializer once it is empty or its final byte is leaving, and the
// next event can be accepted in the following cycle while those bytes drain at up to one
// per cycle, as m_axis_tready allows. Pause events and events for a track at or above
// TRACK_COUNT (other than tempo) send no bytes.
// Depends on mtes_pkg, mtes_track_mem, mtes_tempo_div and mtes_byte_ser.
`timescale 1ns / 1ps
`include "midi_track_event_serializer_core_assert.svh"

module midi_track_event_serializer_core import mtes_pkg::*; #(
	parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] track, [31:4] delta_ticks, [38:32] pitch, [45:39] velocity,
	// [53:46] level, [69:54] gain_ratio, [79:70] beats_per_minute
	input  logic [79:0] s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,  // [2:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	output logic        m_axis_tlast   // last_byte
);

	localparam logic [TRK_W:0] TRK_LIM = (TRK_W + 1)'(TRACK_COUNT);

	state_t                    state_q;
	state_t                    state_d;
	action_t                   act_q;
	logic [TRK_W-1:0]          trk_q;
	logic [DELAY_W-1:0]        delta_q;
	logic [6:0]                pitch_q;
	logic [6:0]                vel_q;
	logic [7:0]                level_q;
	logic signed [15:0]        gain_q;
	logic [BPM_W-1:0]          bpm_q;
	logic                      in_rng_q;
	logic signed [24:0]        prod_q;
	logic [DELAY_W-1:0]        sum_q;
	logic                      accept;
	trk_entry_t                rd_data;
	mem_wr_t                   mem_wr;
	div_stat_t                 div_stat;
	logic                      div_start;
	logic [TEMPO_W-1:0]        div_quo;
	ser_load_t                 ser_ld;
	logic                      ser_ready;
	logic [DELAY_W:0]          sum_full;
	logic [DELAY_W-1:0]        var_val;
	logic [2:0]                ngrp;
	logic [1:0]                vshift;
	logic [MAX_BYTES-1:0][7:0] note_full;
	logic [MAX_BYTES-1:0][7:0] note_b;
	logic [7:0]                note_stat;
	logic [7:0]                vol_new;
	logic [TEMPO_W-1:0]        tempo_val;
	logic [MAX_BYTES-1:0][7:0] ev_bytes;
	logic [2:0]                ev_count;
	trk_entry_t                ev_entry;
	logic                      ev_write;

	assign s_axis_tready = state_q == ST_IDLE;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Event fields, held for the whole event.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(s_axis_tuser);
			trk_q    <= s_axis_tdata[3:0];
			delta_q  <= s_axis_tdata[31:4];
			pitch_q  <= s_axis_tdata[38:32];
			vel_q    <= s_axis_tdata[45:39];
			level_q  <= s_axis_tdata[53:46];
			gain_q   <= s_axis_tdata[69:54];
			bpm_q    <= s_axis_tdata[79:70];
			in_rng_q <= {1'b0, s_axis_tdata[3:0]} < TRK_LIM;
		end
	end

	// Track state memory, read at the address of the incoming event.
	mtes_track_mem #(
		.TRACK_COUNT(TRACK_COUNT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(s_axis_tdata[3:0]),
		.rd_data(rd_data),
		.wr     (mem_wr)
	);

	// Saturating delay sum, shared by note on and pause.
	assign sum_full = {1'b0, delta_q} + {1'b0, rd_data.delay};

	// Arithmetic stage on the entry just read.
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			prod_q <= 25'($signed({1'b0, rd_data.volume}) * gain_q);
			sum_q  <= sum_full[DELAY_W] ? DELAY_MAX : sum_full[DELAY_W-1:0];
		end
	end

	mtes_tempo_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (bpm_q),
		.stat    (div_stat),
		.quotient(div_quo)
	);

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (act_q == ACT_TEMPO && bpm_q != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ser_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Varlen delta: count the 7-bit groups, then drop unused leading bytes.
	always_comb begin
		var_val = (act_q == ACT_NOTE_ON) ? sum_q : delta_q;
		if (var_val[27:21] != '0) begin
			ngrp = 3'd4;
		end else if (var_val[20:14] != '0) begin
			ngrp = 3'd3;
		end else if (var_val[13:7] != '0) begin
			ngrp = 3'd2;
		end else begin
			ngrp = 3'd1;
		end
		vshift    = 2'(3'd4 - ngrp);
		note_stat = ((act_q == ACT_NOTE_ON) ? STAT_NOTE_ON : STAT_NOTE_OFF) | {4'h0, trk_q};
		note_full[0] = {1'b1, var_val[27:21]};
		note_full[1] = {1'b1, var_val[20:14]};
		note_full[2] = {1'b1, var_val[13:7]};
		note_full[3] = {1'b0, var_val[6:0]};
		note_full[4] = note_stat;
		note_full[5] = {1'b0, pitch_q};
		note_full[6] = {1'b0, vel_q};
		note_b       = note_full >> {vshift, 3'b000};
	end

	// Volume event: its level. Ratio result: below one gives one, above 255 gives 255. Zero bpm: all-ones tempo.
	always_comb begin
		if (act_q == ACT_VOLUME) begin
			vol_new = level_q;
		end else if (prod_q < 25'sd256) begin
			vol_new = VOL_MIN;
		end else if (prod_q >= 25'sd65536) begin
			vol_new = VOL_MAX;
		end else begin
			vol_new = prod_q[15:8];
		end
		tempo_val = (bpm_q == '0) ? {TEMPO_W{1'b1}} : div_quo;
	end

	// Event bytes and the entry to write back.
	always_comb begin
		ev_bytes = '0;
		ev_count = 3'd0;
		ev_entry = rd_data;
		ev_write = 1'b0;
		case (act_q)
			ACT_NOTE_ON: begin
				ev_bytes       = note_b;
				ev_count       = 3'(ngrp + 3'd3);
				ev_entry.delay = '0;
				ev_write       = 1'b1;
			end
			ACT_NOTE_OFF: begin
				ev_bytes = note_b;
				ev_count = 3'(ngrp + 3'd3);
			end
			ACT_PROGRAM: begin
				ev_bytes[0] = BYTE_ZERO;
				ev_bytes[1] = STAT_PROGRAM | {4'h0, trk_q};
				ev_bytes[2] = level_q;
				ev_count    = 3'd3;
			end
			ACT_VOLUME, ACT_RATIO: begin
				ev_bytes[0]     = BYTE_ZERO;
				ev_bytes[1]     = STAT_CTRL | {4'h0, trk_q};
				ev_bytes[2]     = CTRL_VOLUME;
				ev_bytes[3]     = vol_new;
				ev_count        = 3'd4;
				ev_entry.volume = vol_new;
				ev_write        = 1'b1;
			end
			ACT_PAUSE: begin
				ev_entry.delay = sum_q;
				ev_write       = 1'b1;
			end
			ACT_TEMPO: begin
				ev_bytes[0] = BYTE_ZERO;
				ev_bytes[1] = META_START;
				ev_bytes[2] = META_TEMPO;
				ev_bytes[3] = META_TEMPO_LN;
				ev_bytes[4] = tempo_val[23:16];
				ev_bytes[5] = tempo_val[15:8];
				ev_bytes[6] = tempo_val[7:0];
				ev_count    = 3'd7;
			end
			ACT_END: begin
				ev_bytes[0] = BYTE_ZERO;
				ev_bytes[1] = META_START;
				ev_bytes[2] = META_END;
				ev_bytes[3] = BYTE_ZERO;
				ev_count    = 3'd4;
			end
			default: begin
				ev_count = 3'd0;
			end
		endcase
		// Out-of-range tracks are dropped, except for tempo.
		if (!in_rng_q && act_q != ACT_TEMPO) begin
			ev_count = 3'd0;
			ev_write = 1'b0;
		end
	end

	// Controller outputs.
	always_comb begin
		div_start    = (state_q == ST_CALC) && (act_q == ACT_TEMPO) && (bpm_q != '0);
		ser_ld.load  = (state_q == ST_EMIT) && ser_ready;
		ser_ld.count = ev_count;
		ser_ld.bytes = ev_bytes;
		mem_wr.en    = (state_q == ST_EMIT) && ser_ready && ev_write;
		mem_wr.addr  = trk_q;
		mem_wr.data  = ev_entry;
	end

	mtes_byte_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ser_ld),
		.ready        (ser_ready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	`MTES_ASSERT_IMPLY(a_load_room, ser_ld.load, ser_ready, "event loaded over unsent bytes")
	`MTES_ASSERT_IMPLY(a_idle_div, s_axis_tready, !div_stat.busy, "input taken during division")
	`MTES_ASSERT_IMPLY(a_tempo_len, ser_ld.load && act_q == ACT_TEMPO, ser_ld.count == 3'd7, "tempo event not seven bytes")
	`MTES_ASSERT_IMPLY(a_wr_range, mem_wr.en, in_rng_q && act_q != ACT_TEMPO, "state write for a dropped event")
	`MTES_ASSERT_NEXT(a_div_emit, div_stat.done, state_q == ST_EMIT, "division result not taken")

endmodule
